FILE: hw/rtl/lsac_pkg.sv
// Package for the LRU shelf with age counters.
// Holds the operation codes, sequencer states, fixed field widths and the emit struct.
// No dependencies.
`default_nettype none

package lsac_pkg;

	localparam int PAGE_BITS     = 16;
	localparam int PORT_KEY_BITS = 64;
	localparam int OP_BITS       = 2;
	localparam int S_TDATA_BITS  = 2 * PORT_KEY_BITS + PAGE_BITS;
	localparam int M_TDATA_BITS  = 2 * PORT_KEY_BITS + PAGE_BITS;
	localparam int MAX_OUT       = 16;

	typedef enum logic [OP_BITS-1:0] {
		OP_PUT  = 2'd0,
		OP_READ = 2'd1,
		OP_DUMP = 2'd2
	} lsac_op_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_AGE   = 5'b00010,
		ST_SHIFT = 5'b00100,
		ST_DRD   = 5'b01000,
		ST_DLD   = 5'b10000
	} lsac_state_t;

	typedef struct packed {
		logic load;
		logic last;
	} lsac_emit_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lsac_mem.sv
// Entry memory of the shelf: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
`default_nettype none

module lsac_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 160,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/lsac_engine.sv
// Sequencer of the shelf: age sweep with search, eviction shift, append and dump walk.
// Drives the entry memory read and write ports. Uses lsac_pkg.
`default_nettype none

module lsac_engine import lsac_pkg::*; #(
	parameter int SLOTS    = 16,
	parameter int AGE_BITS = 16,
	parameter int KEY_BITS = 64,
	localparam int IDX_W = $clog2(SLOTS),
	localparam int CNT_W = $clog2(SLOTS + 1),
	localparam int ENT_W = 2 * KEY_BITS + PAGE_BITS + AGE_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [OP_BITS-1:0]   in_op,
	input  wire logic [KEY_BITS-1:0]  in_title,
	input  wire logic [KEY_BITS-1:0]  in_author,
	input  wire logic [PAGE_BITS-1:0] in_pages,
	input  wire logic                 out_free,
	output lsac_emit_t                emit,
	output logic                      mem_we,
	output logic [IDX_W-1:0]          mem_waddr,
	output logic [ENT_W-1:0]          mem_wdata,
	output logic                      mem_re,
	output logic [IDX_W-1:0]          mem_raddr,
	input  wire logic [ENT_W-1:0]     mem_rdata
);

	localparam int DUMP_MAX = (SLOTS < MAX_OUT) ? SLOTS : MAX_OUT;
	localparam logic [CNT_W-1:0] SLOTS_C    = CNT_W'(SLOTS);
	localparam logic [CNT_W-1:0] DUMP_MAX_C = CNT_W'(DUMP_MAX);
	localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(SLOTS - 1);

	lsac_state_t          state_q;
	lsac_op_t             op_q;
	logic [KEY_BITS-1:0]  title_q;
	logic [KEY_BITS-1:0]  author_q;
	logic [PAGE_BITS-1:0] pages_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     rd_idx_q;
	logic                 valid_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic                 found_q;
	logic [AGE_BITS-1:0]  max_q;
	logic [IDX_W-1:0]     victim_q;

	logic                 age_rd;
	logic                 shift_rd;
	logic                 sweep_done;
	logic                 full;
	logic                 hit;
	logic [AGE_BITS-1:0]  r_age;
	logic [AGE_BITS-1:0]  aged;
	logic [AGE_BITS-1:0]  new_age;
	logic [ENT_W-1:0]     new_ent;
	logic [CNT_W-1:0]     dump_n;
	logic                 dump_last;

	assign in_ready   = (state_q == ST_IDLE);
	assign full       = (count_q >= SLOTS_C);
	assign age_rd     = (state_q == ST_AGE) && (rd_idx_q < count_q);
	assign shift_rd   = (state_q == ST_SHIFT) && (rd_idx_q < SLOTS_C);
	assign sweep_done = !age_rd && !shift_rd && !valid_s1;
	assign r_age      = mem_rdata[ENT_W-1 -: AGE_BITS];
	assign aged       = (r_age == {AGE_BITS{1'b1}}) ? r_age : r_age + AGE_BITS'(1);
	assign hit        = (op_q == OP_READ) && !found_q
		&& (mem_rdata[KEY_BITS-1:0] == title_q);
	assign new_age    = hit ? '0 : aged;
	assign new_ent    = {AGE_BITS'(0), pages_q, author_q, title_q};
	assign dump_n     = (count_q > DUMP_MAX_C) ? DUMP_MAX_C : count_q;
	assign dump_last  = (rd_idx_q + CNT_W'(1) == dump_n);

	assign mem_re    = age_rd || shift_rd || (state_q == ST_DRD);
	assign mem_raddr = rd_idx_q[IDX_W-1:0];

	assign emit = '{load: (state_q == ST_DLD) && out_free, last: dump_last};

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_s1;
		mem_wdata = mem_rdata;
		if (state_q == ST_AGE) begin
			if (valid_s1) begin
				mem_we    = 1'b1;
				mem_wdata = {new_age, mem_rdata[ENT_W-AGE_BITS-1:0]};
			end else if (sweep_done && op_q == OP_PUT && !full) begin
				mem_we    = 1'b1;
				mem_waddr = count_q[IDX_W-1:0];
				mem_wdata = new_ent;
			end
		end else if (state_q == ST_SHIFT) begin
			if (valid_s1) begin
				mem_we    = 1'b1;
				mem_waddr = idx_s1 - IDX_W'(1);
			end else if (sweep_done) begin
				mem_we    = 1'b1;
				mem_waddr = LAST_IDX;
				mem_wdata = new_ent;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			op_q     <= OP_PUT;
			title_q  <= '0;
			author_q <= '0;
			pages_q  <= '0;
			count_q  <= '0;
			rd_idx_q <= '0;
			valid_s1 <= 1'b0;
			idx_s1   <= '0;
			found_q  <= 1'b0;
			max_q    <= '0;
			victim_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q     <= lsac_op_t'(in_op);
						title_q  <= in_title;
						author_q <= in_author;
						pages_q  <= in_pages;
						rd_idx_q <= '0;
						valid_s1 <= 1'b0;
						found_q  <= 1'b0;
						max_q    <= '0;
						victim_q <= '0;
						unique case (in_op)
							OP_PUT, OP_READ: state_q <= ST_AGE;
							OP_DUMP:         state_q <= (dump_n != '0) ? ST_DRD : ST_IDLE;
							default:         state_q <= ST_IDLE;
						endcase
					end
				end
				ST_AGE: begin
					if (age_rd) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end
					valid_s1 <= age_rd;
					idx_s1   <= rd_idx_q[IDX_W-1:0];
					if (valid_s1) begin
						if (hit) begin
							found_q <= 1'b1;
						end
						if (aged > max_q) begin
							max_q    <= aged;
							victim_q <= idx_s1;
						end
					end
					if (sweep_done) begin
						if (op_q == OP_PUT && full) begin
							rd_idx_q <= CNT_W'(victim_q) + CNT_W'(1);
							state_q  <= ST_SHIFT;
						end else begin
							if (op_q == OP_PUT) begin
								count_q <= count_q + CNT_W'(1);
							end
							state_q <= ST_IDLE;
						end
					end
				end
				ST_SHIFT: begin
					if (shift_rd) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end
					valid_s1 <= shift_rd;
					idx_s1   <= rd_idx_q[IDX_W-1:0];
					if (sweep_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DRD: begin
					state_q <= ST_DLD;
				end
				ST_DLD: begin
					if (out_free) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
						state_q  <= dump_last ? ST_IDLE : ST_DRD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/lru_shelf_with_age_counters.sv
// LRU shelf with age counters, top level: stream ports, output register, engine and memory.
// Depends on lsac_pkg, lsac_mem and lsac_engine.
//
// Usage: commands arrive on the s_axis channel, op in s_axis_tuser (0 put, 1 read by
// title, 2 dump). A put stores title, author and page count; when the shelf is full the
// first entry with the greatest age is evicted and later entries move down. A read clears
// the age of the first matching title. Put and read first age every stored entry.
// A dump streams the stored entries (up to 16) on m_axis in order, m_axis_tlast on the
// final one; an empty shelf dumps nothing. Op 3 is dropped.
// Timing: one transaction is taken at a time. Put and read walk every stored entry
// through the memory's single read port, and a put into a full shelf then shifts every
// entry after the victim down by one slot before the new entry goes into the last slot.
// A dump reads each entry from memory, then loads it into the output register, and
// waits there while m_axis_tready is low.
// Reset empties the shelf at once; memory contents need no clearing.
// When the receiver stalls the dump pauses on the held output register; the next command
// is taken as soon as the last dumped entry sits in that register.
`default_nettype none

module lru_shelf_with_age_counters import lsac_pkg::*; #(
	parameter int SLOTS    = 16,
	parameter int AGE_BITS = 16,
	parameter int KEY_BITS = 64
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_axis_tvalid,
	output logic                         s_axis_tready,
	// title_key[63:0], author_key[127:64], page_count[143:128]
	input  wire logic [S_TDATA_BITS-1:0] s_axis_tdata,
	// op[1:0]
	input  wire logic [OP_BITS-1:0]      s_axis_tuser,
	output logic                         m_axis_tvalid,
	input  wire logic                    m_axis_tready,
	// out_title[63:0], out_author[127:64], out_pages[143:128]
	output logic [M_TDATA_BITS-1:0]      m_axis_tdata,
	output logic                         m_axis_tlast
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam int ENT_W = 2 * KEY_BITS + PAGE_BITS + AGE_BITS;

	lsac_emit_t           emit;
	logic                 out_free;
	logic                 mem_we;
	logic [IDX_W-1:0]     mem_waddr;
	logic [ENT_W-1:0]     mem_wdata;
	logic                 mem_re;
	logic [IDX_W-1:0]     mem_raddr;
	logic [ENT_W-1:0]     mem_rdata;

	logic                 out_valid_q;
	logic                 out_last_q;
	logic [KEY_BITS-1:0]  out_title_q;
	logic [KEY_BITS-1:0]  out_author_q;
	logic [PAGE_BITS-1:0] out_pages_q;

	assign out_free = !out_valid_q || m_axis_tready;

	lsac_mem #(
		.DEPTH (SLOTS),
		.WIDTH (ENT_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	lsac_engine #(
		.SLOTS    (SLOTS),
		.AGE_BITS (AGE_BITS),
		.KEY_BITS (KEY_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (s_axis_tuser),
		.in_title  (s_axis_tdata[KEY_BITS-1:0]),
		.in_author (s_axis_tdata[PORT_KEY_BITS +: KEY_BITS]),
		.in_pages  (s_axis_tdata[2*PORT_KEY_BITS +: PAGE_BITS]),
		.out_free  (out_free),
		.emit      (emit),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.load) begin
			out_title_q  <= mem_rdata[KEY_BITS-1:0];
			out_author_q <= mem_rdata[KEY_BITS +: KEY_BITS];
			out_pages_q  <= mem_rdata[2*KEY_BITS +: PAGE_BITS];
			out_last_q   <= emit.last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {out_pages_q, PORT_KEY_BITS'(out_author_q),
		PORT_KEY_BITS'(out_title_q)};

endmodule

`default_nettype wire

FILE: sim/shelf_checker.sv
// Checker for the LRU shelf: watches both stream channels, keeps its own shelf model
// and compares each dumped entry against the predicted one. Depends on lsac_pkg.
`timescale 1ns / 1ps

module shelf_checker import lsac_pkg::*; #(
	parameter int SLOTS    = 16,
	parameter int AGE_BITS = 16,
	parameter int KEY_BITS = 64
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_axis_tvalid,
	input  wire logic                    s_axis_tready,
	// title_key[63:0], author_key[127:64], page_count[143:128]
	input  wire logic [S_TDATA_BITS-1:0] s_axis_tdata,
	// op[1:0]
	input  wire logic [OP_BITS-1:0]      s_axis_tuser,
	input  wire logic                    m_axis_tvalid,
	input  wire logic                    m_axis_tready,
	// out_title[63:0], out_author[127:64], out_pages[143:128]
	input  wire logic [M_TDATA_BITS-1:0] m_axis_tdata,
	input  wire logic                    m_axis_tlast,
	output int                           fail_count,
	output int                           pending
);

	typedef struct {
		logic [PORT_KEY_BITS-1:0] title;
		logic [PORT_KEY_BITS-1:0] author;
		logic [PAGE_BITS-1:0]     pages;
		logic                     last;
	} shelf_entry_t;

	localparam logic [PORT_KEY_BITS-1:0] KEY_MASK = {PORT_KEY_BITS{1'b1}} >> (64 - KEY_BITS);
	localparam logic [AGE_BITS-1:0]      AGE_MAX  = '1;

	logic [PORT_KEY_BITS-1:0] title_mem [SLOTS];
	logic [PORT_KEY_BITS-1:0] author_mem[SLOTS];
	logic [PAGE_BITS-1:0]     page_mem  [SLOTS];
	logic [AGE_BITS-1:0]      age_mem   [SLOTS];
	int                       shelf_count;
	int                       mismatches;
	shelf_entry_t             dump_q[$];
	shelf_entry_t             got;
	shelf_entry_t             want;

	task automatic age_entries();
		for (int i = 0; i < shelf_count; i++) begin
			if (age_mem[i] != AGE_MAX)
				age_mem[i] = age_mem[i] + 1'b1;
		end
	endtask

	task automatic store_entry(input int idx, input logic [PORT_KEY_BITS-1:0] title,
			input logic [PORT_KEY_BITS-1:0] author, input logic [PAGE_BITS-1:0] pages);
		title_mem[idx]  = title & KEY_MASK;
		author_mem[idx] = author & KEY_MASK;
		page_mem[idx]   = pages;
		age_mem[idx]    = '0;
	endtask

	task automatic shelf_apply(input logic [OP_BITS-1:0] op,
			input logic [PORT_KEY_BITS-1:0] title, input logic [PORT_KEY_BITS-1:0] author,
			input logic [PAGE_BITS-1:0] pages);
		int           victim;
		int           n;
		bit           found;
		shelf_entry_t e;
		title = title & KEY_MASK;
		case (op)
			OP_PUT: begin
				age_entries();
				if (shelf_count < SLOTS) begin
					store_entry(shelf_count, title, author, pages);
					shelf_count++;
				end else begin
					// oldest goes, lowest index wins a tie
					victim = 0;
					for (int i = 1; i < SLOTS; i++) begin
						if (age_mem[i] > age_mem[victim])
							victim = i;
					end
					for (int i = victim; i + 1 < SLOTS; i++) begin
						title_mem[i]  = title_mem[i + 1];
						author_mem[i] = author_mem[i + 1];
						page_mem[i]   = page_mem[i + 1];
						age_mem[i]    = age_mem[i + 1];
					end
					store_entry(SLOTS - 1, title, author, pages);
				end
			end
			OP_READ: begin
				age_entries();
				found = 1'b0;
				for (int i = 0; i < shelf_count && !found; i++) begin
					if (title_mem[i] == title) begin
						age_mem[i] = '0;
						found = 1'b1;
					end
				end
			end
			OP_DUMP: begin
				n = (shelf_count > MAX_OUT) ? MAX_OUT : shelf_count;
				for (int i = 0; i < n; i++) begin
					e.title  = title_mem[i];
					e.author = author_mem[i];
					e.pages  = page_mem[i];
					e.last   = (i + 1 == n);
					dump_q.push_back(e);
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shelf_count = 0;
			mismatches  = 0;
			dump_q.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.title  = m_axis_tdata[PORT_KEY_BITS-1:0];
				got.author = m_axis_tdata[2*PORT_KEY_BITS-1:PORT_KEY_BITS];
				got.pages  = m_axis_tdata[M_TDATA_BITS-1:2*PORT_KEY_BITS];
				got.last   = m_axis_tlast;
				if (dump_q.size() == 0) begin
					$display("%0t: unexpected transaction, expected none, got title %h author %h pages %h last %b",
						$time, got.title, got.author, got.pages, got.last);
					mismatches++;
				end else begin
					want = dump_q.pop_front();
					if (got.title !== want.title) begin
						$display("%0t: title mismatch, expected %h, got %h",
							$time, want.title, got.title);
						mismatches++;
					end
					if (got.author !== want.author) begin
						$display("%0t: author mismatch, expected %h, got %h",
							$time, want.author, got.author);
						mismatches++;
					end
					if (got.pages !== want.pages) begin
						$display("%0t: pages mismatch, expected %h, got %h",
							$time, want.pages, got.pages);
						mismatches++;
					end
					if (got.last !== want.last) begin
						$display("%0t: last mismatch, expected %b, got %b",
							$time, want.last, got.last);
						mismatches++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				shelf_apply(s_axis_tuser, s_axis_tdata[PORT_KEY_BITS-1:0],
					s_axis_tdata[2*PORT_KEY_BITS-1:PORT_KEY_BITS],
					s_axis_tdata[S_TDATA_BITS-1:2*PORT_KEY_BITS]);
			fail_count <= mismatches;
			pending    <= dump_q.size();
		end
	end

endmodule

FILE: sim/testbench.sv
// Top of the LRU shelf testbench: clock, reset, command stimulus and dump back-pressure.
// Depends on lsac_pkg, lru_shelf_with_age_counters and shelf_checker.
`timescale 1ns / 1ps

module testbench;
	import lsac_pkg::*;

	localparam logic [OP_BITS-1:0] OP_NONE = 2'd3;
	localparam int                 LIMIT   = 500000;

	logic                    clk;
	logic                    arst_n;
	logic                    s_axis_tvalid;
	logic                    s_axis_tready;
	logic [S_TDATA_BITS-1:0] s_axis_tdata;
	logic [OP_BITS-1:0]      s_axis_tuser;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [M_TDATA_BITS-1:0] m_axis_tdata;
	logic                    m_axis_tlast;
	int                      fail_count;
	int                      pending;
	int                      cycle_cnt = 0;
	int                      stall_cnt = 0;
	logic [1:0]              stall_mode = 2'd0;
	int                      burst_left = 0;
	logic [PORT_KEY_BITS-1:0] title_pool[$];

	lru_shelf_with_age_counters dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	shelf_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// receiver back-pressure in one of four randomly chosen modes
	always @(posedge clk) begin
		stall_cnt <= stall_cnt + 1;
		if (stall_cnt % 64 == 0)
			stall_mode <= 2'($urandom_range(0, 3));
		case (stall_mode)
			2'd0: m_axis_tready <= 1'b1;
			2'd1: m_axis_tready <= 1'($urandom);
			2'd2: m_axis_tready <= ($urandom_range(0, 3) == 0);
			default: m_axis_tready <= (stall_cnt % 8 != 0);
		endcase
	end

	function automatic logic [PORT_KEY_BITS-1:0] rand_key();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [PORT_KEY_BITS-1:0] pool_title();
		return title_pool[$urandom_range(0, title_pool.size() - 1)];
	endfunction

	task automatic send(input logic [OP_BITS-1:0] op, input logic [PORT_KEY_BITS-1:0] title,
			input logic [PORT_KEY_BITS-1:0] author, input logic [PAGE_BITS-1:0] pages);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 8);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {pages, author, title};
		s_axis_tuser  <= op;
		do @(posedge clk); while (!s_axis_tready);
		if (op == OP_PUT) begin
			title_pool.push_back(title);
			if (title_pool.size() > 24)
				void'(title_pool.pop_front());
		end
	endtask

	initial begin
		logic [PORT_KEY_BITS-1:0] t;
		int                       r;
		int                       done;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= OP_PUT;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty dump, dropped op, extremes, duplicates, miss, fill, eviction
		send(OP_DUMP, rand_key(), rand_key(), 16'hffff);
		send(OP_NONE, rand_key(), rand_key(), 16'h1234);
		send(OP_PUT, '0, '0, 16'h0000);
		send(OP_PUT, '1, '1, 16'hffff);
		send(OP_PUT, '1, 64'h5555_5555_5555_5555, 16'h0001);
		send(OP_READ, '1, '0, 16'h0000);
		send(OP_READ, 64'h0000_0000_0000_0123, '1, 16'hffff);
		send(OP_DUMP, '0, '0, 16'h0000);
		send(OP_NONE, '1, '1, 16'hffff);
		for (int i = 0; i < 13; i++)
			send(OP_PUT, rand_key(), rand_key(), 16'($urandom));
		send(OP_PUT, 64'haaaa_aaaa_aaaa_aaaa, 64'h8000_0000_0000_0001, 16'h8000);
		send(OP_DUMP, '1, '1, 16'hffff);

		done = 0;
		while (done < 96) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				t = ($urandom_range(0, 6) == 0) ? pool_title() : rand_key();
				send(OP_PUT, t, rand_key(), 16'($urandom));
				done++;
			end else if (r < 80) begin
				t = ($urandom_range(0, 4) != 0) ? pool_title() : rand_key();
				send(OP_READ, t, rand_key(), 16'($urandom));
				done++;
			end else if (r < 95) begin
				send(OP_DUMP, rand_key(), rand_key(), 16'($urandom));
				done++;
			end else begin
				send(OP_NONE, rand_key(), rand_key(), 16'($urandom));
			end
		end
		s_axis_tvalid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (48) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/lsac_pkg.sv
hw/rtl/lsac_mem.sv
hw/rtl/lsac_engine.sv
hw/rtl/lru_shelf_with_age_counters.sv
sim/shelf_checker.sv
sim/testbench.sv
